### rtl/lru_page_replacement_top_macros.svh
// assertion macros shared by the lru page replacement rtl
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication, clocked on clock and quiet during reset
`define LRUPR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock and quiet during reset
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lrupr_pkg.sv
// shared constants, types and helpers for the lru page replacement block
`timescale 1ns / 1ps

package lrupr_pkg;

   // fixed field widths of the ports
   localparam int PAGE_FIELD_W  = 16;
   localparam int FRAME_FIELD_W = 4;
   localparam int CSR_W         = 5;
   localparam int COUNT_W       = 32;

   // build defaults and register reset value
   localparam int DEF_FRAMES    = 16;
   localparam int DEF_PAGE_BITS = 16;
   localparam int FRAMES_RESET  = 16;

   // per-update control broadcast to every cell
   typedef struct packed {
      logic upd;
      logic hit;
      logic fill;
      logic evict;
   } lrupr_ctrl_type;

   // zero acts as one, anything above the built size acts as the built size
   function automatic int clamp_frames(input int value, input int frames);
      int n;
      n = value;
      if (n < 1) begin
         n = 1;
      end
      if (n > frames) begin
         n = frames;
      end
      return n;
   endfunction

endpackage

### rtl/lrupr_cell.sv
// one frame of the page table: resident page, valid mark and recency rank
`timescale 1ns / 1ps

module lrupr_cell #(
   parameter int PAGE_BITS = lrupr_pkg::DEF_PAGE_BITS,
   parameter int RANK_W    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       active,
   input  logic                       prev_valid,
   input  logic                       look,
   input  logic [PAGE_BITS-1:0]       lookup_page,
   input  logic [PAGE_BITS-1:0]       new_page,
   input  logic                       flush,
   input  lrupr_pkg::lrupr_ctrl_type  ctrl,
   input  logic [RANK_W-1:0]          hit_rank,
   input  logic [RANK_W-1:0]          last_rank,
   output logic                       valid,
   output logic                       match,
   output logic                       empty_slot,
   output logic                       victim,
   output logic                       sel,
   output logic [RANK_W-1:0]          rank,
   output logic [PAGE_BITS-1:0]       page
);
   import lrupr_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 match_ff, match_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 bump;

   // frame status seen by the neighbours and the top level
   assign valid      = valid_ff;
   assign match      = match_ff;
   assign rank       = rank_ff;
   assign page       = page_ff;
   // valid frames form a prefix, so the first empty one is frame 0 or sits right after a valid one
   assign empty_slot = active & ~valid_ff & prev_valid;
   assign victim     = active & valid_ff & (rank_ff == last_rank);
   assign sel        = ctrl.hit ? match_ff : (ctrl.fill ? empty_slot : victim);

   // frames more recent than the hit one age by one, on a miss every other frame ages
   assign bump = valid_ff & active & (ctrl.hit ? (rank_ff < hit_rank) : 1'b1);

   // next state of the frame
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      page_in  = page_ff;
      match_in = match_ff;
      if (look) begin
         match_in = valid_ff & active & (page_ff == lookup_page);
      end
      if (flush) begin
         valid_in = 1'b0;
         rank_in  = '0;
      end else if (ctrl.upd) begin
         if (sel) begin
            rank_in = '0;
            if (!ctrl.hit) begin
               valid_in = 1'b1;
               page_in  = new_page;
            end
         end else if (bump) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
   end

   // page storage
   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

### rtl/lru_page_replacement_top.sv
// When a request is accepted, every frame cell compares the page against its
// resident page in parallel and registers the match; in the update state that follows,
// the cells update their recency ranks and the result is loaded into the
// output register. The result register is separate from the request side, so a new
// request is accepted while the previous result still waits; the update cycle holds
// only while that result has not been taken. A write to the frames_in_use register
// empties the table and is accepted whenever no request is in its update cycle.
`timescale 1ns / 1ps

module lru_page_replacement_top #(
   parameter int FRAMES    = lrupr_pkg::DEF_FRAMES,
   parameter int PAGE_BITS = lrupr_pkg::DEF_PAGE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lrupr_pkg::PAGE_FIELD_W-1:0]  req_page_number,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [lrupr_pkg::FRAME_FIELD_W-1:0] rsp_frame_index,
   output logic                                rsp_evicted,
   output logic [lrupr_pkg::PAGE_FIELD_W-1:0]  rsp_evicted_page,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_hit_total,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_fault_total,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrupr_pkg::CSR_W-1:0]         csr_frames_in_use
);
   import lrupr_pkg::*;

   `include "lru_page_replacement_top_macros.svh"

   localparam int RANK_W = $clog2(FRAMES);
   localparam int CNT_W  = $clog2(FRAMES + 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [PAGE_BITS-1:0] page_ff;
   logic [COUNT_W-1:0]   hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]   fault_count_ff, fault_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [FRAME_FIELD_W-1:0] rsp_frame_index_ff;
   logic                 rsp_evicted_ff;
   logic [PAGE_FIELD_W-1:0]  rsp_evicted_page_ff;

   logic                 accept;
   logic                 upd;
   logic                 csr_write;
   logic [PAGE_BITS-1:0] lookup_page;
   logic [31:0]          req_ext;
   logic [CNT_W-1:0]     n_less;
   logic [RANK_W-1:0]    last_rank;
   lrupr_ctrl_type       ctrl;

   logic [FRAMES-1:0]    active_vec;
   logic [FRAMES-1:0]    valid_vec;
   logic [FRAMES-1:0]    match_vec;
   logic [FRAMES-1:0]    empty_vec;
   logic [FRAMES-1:0]    victim_vec;
   logic [FRAMES-1:0]    sel_vec;
   logic [RANK_W-1:0]    rank_vec [FRAMES];
   logic [PAGE_BITS-1:0] page_vec [FRAMES];

   logic [RANK_W-1:0]    hit_rank;
   logic [RANK_W-1:0]    frame_idx;
   logic [PAGE_BITS-1:0] victim_page;
   logic [31:0]          idx_ext;
   logic [31:0]          ev_ext;

   // handshakes
   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff == ST_UPDATE);
   assign upd       = (state_ff == ST_UPDATE) & (~rsp_valid_ff | ~rsp_stall);
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_valid & csr_ready;

   // page masked to the built page width
   assign req_ext     = 32'(req_page_number);
   assign lookup_page = req_ext[PAGE_BITS-1:0];

   // least recent rank among a full set of active frames
   assign n_less    = n_ff - 1'b1;
   assign last_rank = n_less[RANK_W-1:0];

   // row of frame cells, each handing its valid mark to the next one
   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      assign active_vec[i] = (n_ff > CNT_W'(i));
      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .RANK_W    (RANK_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .active      (active_vec[i]),
         .prev_valid  ((i == 0) ? 1'b1 : valid_vec[(i == 0) ? 0 : i - 1]),
         .look        (accept),
         .lookup_page (lookup_page),
         .new_page    (page_ff),
         .flush       (csr_write),
         .ctrl        (ctrl),
         .hit_rank    (hit_rank),
         .last_rank   (last_rank),
         .valid       (valid_vec[i]),
         .match       (match_vec[i]),
         .empty_slot  (empty_vec[i]),
         .victim      (victim_vec[i]),
         .sel         (sel_vec[i]),
         .rank        (rank_vec[i]),
         .page        (page_vec[i])
      );
   end

   // update control broadcast to the cells
   always_comb begin
      ctrl.upd   = upd;
      ctrl.hit   = |match_vec;
      ctrl.fill  = ~(|match_vec) & (|empty_vec);
      ctrl.evict = ~(|match_vec) & ~(|empty_vec);
   end

   // gather rank of the hit frame, chosen frame index and evicted page
   always_comb begin
      hit_rank    = '0;
      frame_idx   = '0;
      victim_page = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (match_vec[i]) begin
            hit_rank = hit_rank | rank_vec[i];
         end
         if (sel_vec[i]) begin
            frame_idx = frame_idx | RANK_W'(i);
         end
         if (victim_vec[i]) begin
            victim_page = victim_page | page_vec[i];
         end
      end
   end

   assign idx_ext = 32'(frame_idx);
   assign ev_ext  = 32'(victim_page);

   // sequencer, register and counters next state
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      hit_count_in   = hit_count_ff;
      fault_count_in = fault_count_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write) begin
         n_in = CNT_W'(clamp_frames(int'(csr_frames_in_use), FRAMES));
      end
      if (upd) begin
         rsp_valid_in = 1'b1;
         if (ctrl.hit) begin
            if (!(&hit_count_ff)) begin
               hit_count_in = hit_count_ff + 1'b1;
            end
         end else if (!(&fault_count_ff)) begin
            fault_count_in = fault_count_ff + 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         n_ff           <= CNT_W'(clamp_frames(FRAMES_RESET, FRAMES));
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         n_ff           <= n_in;
         hit_count_ff   <= hit_count_in;
         fault_count_ff <= fault_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // request page and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= lookup_page;
      end
      if (upd) begin
         rsp_hit_ff          <= ctrl.hit;
         rsp_frame_index_ff  <= idx_ext[FRAME_FIELD_W-1:0];
         rsp_evicted_ff      <= ctrl.evict;
         rsp_evicted_page_ff <= ctrl.evict ? ev_ext[PAGE_FIELD_W-1:0] : '0;
      end
   end

   // result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_index  = rsp_frame_index_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_hit_total    = hit_count_ff;
   assign rsp_fault_total  = fault_count_ff;

   // checks
   `LRUPR_ASSERT_IMPL(a_one_frame_chosen, state_ff == ST_UPDATE, $onehot(sel_vec), "update must choose exactly one frame")
   `LRUPR_ASSERT_IMPL(a_no_inactive_valid, 1'b1, (valid_vec & ~active_vec) == '0, "valid frame outside the active set")
   `LRUPR_ASSERT_NEXT(a_update_gives_result, upd, rsp_valid_ff, "update did not raise a result")
   `LRUPR_ASSERT_NEXT(a_fault_counted, upd && !ctrl.hit && !(&fault_count_ff), fault_count_ff == $past(fault_count_ff) + 1'b1, "fault not counted")

endmodule
